// ----- rtl/abc_to_qd0_frame_transform_defines.svh -----
// assertion macros for the abc to qd0 frame transform
// used by the top level only; expects clk and rst_n in scope
`ifndef ABC_TO_QD0_FRAME_TRANSFORM_DEFINES_SVH
`define ABC_TO_QD0_FRAME_TRANSFORM_DEFINES_SVH

// same-cycle implication, held off during reset
`define A2Q_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define A2Q_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/a2q_pkg.sv -----
// shared constants, types and helper functions of the abc to qd0 transform
// holds the quarter-wave sine table, built at elaboration; no dependencies
`default_nettype none

package a2q_pkg;

  localparam int TABLE_ADDR_BITS = 10;
  localparam int TRIG_BITS       = 16;
  localparam int TBL_N           = 1 << TABLE_ADDR_BITS;
  localparam int ADDR_W          = TABLE_ADDR_BITS + 1;

  localparam int SAMPLE_W = 16;
  localparam int ZSUM_W   = SAMPLE_W + 2;
  localparam int PROD_W   = TRIG_BITS + 16;
  localparam int SUM_W    = TRIG_BITS + 17;
  localparam int MAG_W    = SUM_W - 1;
  localparam int U_W      = MAG_W + 3;
  localparam int QUO_W    = 18;
  localparam int QD_W     = 17;

  localparam int NUM_STAGES = 7;

  localparam logic [15:0] THIRD_TURN = 16'd21845;

  // rounding offset for (4*|S| + 3*2^(TRIG_BITS-1)) >> TRIG_BITS
  localparam logic [U_W-1:0] RND_OFS = U_W'(3) << (TRIG_BITS - 1);

  // divide by three: multiply by floor(2^20/3), one correction step later
  localparam int               DIV3_SHIFT = 20;
  localparam logic [QUO_W:0]   DIV3_RECIP = 19'd349525;
  localparam int               DIV3_PW    = QUO_W + DIV3_SHIFT;

  localparam logic signed [QD_W-1:0] SAT_MIN = 17'h10000;
  localparam logic signed [QD_W-1:0] SAT_MAX = 17'h0FFFF;
  localparam logic [QUO_W-1:0]       MAG_MAX_POS = QUO_W'(65535);
  localparam logic [QUO_W-1:0]       MAG_MAX_NEG = QUO_W'(65536);

  // table build constants
  localparam logic [63:0] PI_HALF_Q32 = 64'd6746518852;
  localparam logic [63:0] TBL_DEN     = 64'(TBL_N) * 64'd4;
  localparam logic [63:0] TBL_HALF    = 64'(TBL_N) * 64'd2;
  localparam logic [63:0] TRIG_FULL   = 64'd1 << (TRIG_BITS - 1);
  localparam logic [63:0] TAYLOR_DIV [16] = '{
    64'd1,   64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156, 64'd210,
    64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930
  };

  typedef logic [TRIG_BITS-1:0] sine_tbl_t [TBL_N+1];

  // stage 2 contents handed from the lookup to the multiplier
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
    logic signed [SAMPLE_W-1:0] c;
    logic [1:0]                 quad_a;
    logic [1:0]                 quad_m;
    logic [1:0]                 quad_p;
    logic [TRIG_BITS-1:0]       lo_a;
    logic [TRIG_BITS-1:0]       hi_a;
    logic [TRIG_BITS-1:0]       lo_m;
    logic [TRIG_BITS-1:0]       hi_m;
    logic [TRIG_BITS-1:0]       lo_p;
    logic [TRIG_BITS-1:0]       hi_p;
    logic signed [ZSUM_W-1:0]   zsum;
  } lut_data_t;

  // stage 4 contents handed from the multiplier to the scaler
  typedef struct packed {
    logic signed [SUM_W-1:0] sq;
    logic signed [SUM_W-1:0] sd;
    logic                    z_neg;
    logic [QUO_W-1:0]        z_mag1;
    logic [QUO_W-1:0]        z_est;
  } mac_data_t;

  // q30 taylor series of sin(x), x in q30
  function automatic logic [63:0] sine_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic        done;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    done = 1'b0;
    for (int n = 1; n < 16; n++) begin
      if (!done) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[n];
        if (term == 64'd0) begin
          done = 1'b1;
        end else if (n[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    return sum;
  endfunction

  function automatic sine_tbl_t build_sine_tbl();
    sine_tbl_t   tbl;
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] e;
    for (int i = 0; i <= TBL_N; i++) begin
      x = (PI_HALF_Q32 * 64'(i) + TBL_HALF) / TBL_DEN;
      s = sine_q30(x);
      e = ((s << (TRIG_BITS - 1)) + (64'd1 << 29)) >> 30;
      if (e > TRIG_FULL) begin
        e = TRIG_FULL;
      end
      tbl[i] = e[TRIG_BITS-1:0];
    end
    return tbl;
  endfunction

  localparam sine_tbl_t SINE_TBL = build_sine_tbl();

  // table magnitude with quadrant sign applied
  function automatic logic signed [TRIG_BITS:0] trig_val(input logic [TRIG_BITS-1:0] mag,
                                                         input logic neg);
    logic signed [TRIG_BITS:0] v;
    v = signed'({1'b0, mag});
    return neg ? -v : v;
  endfunction

  // lower bound of v/3, off by at most one
  function automatic logic [QUO_W-1:0] div3_est(input logic [QUO_W-1:0] v);
    logic [DIV3_PW-1:0] p;
    p = DIV3_PW'(v) * DIV3_PW'(DIV3_RECIP);
    return p[DIV3_SHIFT +: QUO_W];
  endfunction

  function automatic logic [QUO_W-1:0] div3_fix(input logic [QUO_W-1:0] v,
                                                input logic [QUO_W-1:0] est);
    logic [QUO_W-1:0] r;
    r = v - (est + (est << 1));
    return (r >= QUO_W'(3)) ? est + QUO_W'(1) : est;
  endfunction

  function automatic logic signed [QD_W-1:0] sat_qd(input logic [QUO_W-1:0] m,
                                                   input logic neg);
    logic [QUO_W-1:0] nm;
    logic signed [QD_W-1:0] r;
    nm = -m;
    if (neg) begin
      r = (m > MAG_MAX_NEG) ? SAT_MIN : signed'(nm[QD_W-1:0]);
    end else begin
      r = (m > MAG_MAX_POS) ? SAT_MAX : signed'(m[QD_W-1:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/a2q_rom.sv -----
// two-port read-only sine table with registered read data
// contents come from a2q_pkg::SINE_TBL
`default_nettype none

module a2q_rom (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [a2q_pkg::ADDR_W-1:0]        addr_lo,
  input  wire logic [a2q_pkg::ADDR_W-1:0]        addr_hi,
  output logic      [a2q_pkg::TRIG_BITS-1:0]     data_lo,
  output logic      [a2q_pkg::TRIG_BITS-1:0]     data_hi
);

  logic [a2q_pkg::TRIG_BITS-1:0] data_lo_r;
  logic [a2q_pkg::TRIG_BITS-1:0] data_hi_r;

  always_ff @(posedge clk) begin
    if (en) begin
      data_lo_r <= a2q_pkg::SINE_TBL[addr_lo];
      data_hi_r <= a2q_pkg::SINE_TBL[addr_hi];
    end
  end

  assign data_lo = data_lo_r;
  assign data_hi = data_hi_r;

endmodule

`default_nettype wire

// ----- rtl/a2q_lookup.sv -----
// stages 1 and 2: shifted angles, table addresses and table reads
// depends on a2q_pkg and a2q_rom
`default_nettype none

module a2q_lookup (
  input  wire logic                                clk,
  input  wire logic [1:0]                          en,
  input  wire logic [15:0]                         angle,
  input  wire logic signed [a2q_pkg::SAMPLE_W-1:0] phase_a,
  input  wire logic signed [a2q_pkg::SAMPLE_W-1:0] phase_b,
  input  wire logic signed [a2q_pkg::SAMPLE_W-1:0] phase_c,
  output a2q_pkg::lut_data_t                       lut
);

  localparam int AB = a2q_pkg::TABLE_ADDR_BITS;
  localparam int AW = a2q_pkg::ADDR_W;

  logic [15:0] angle_m;
  logic [15:0] angle_p;

  // stage 1
  logic [AB-1:0] k_a_r, k_m_r, k_p_r;
  logic [1:0]    q1_a_r, q1_m_r, q1_p_r;
  logic signed [a2q_pkg::SAMPLE_W-1:0] a1_r, b1_r, c1_r;

  // stage 2
  logic [1:0] q2_a_r, q2_m_r, q2_p_r;
  logic signed [a2q_pkg::SAMPLE_W-1:0] a2_r, b2_r, c2_r;
  logic signed [a2q_pkg::ZSUM_W-1:0]   zsum_r;
  logic signed [a2q_pkg::ZSUM_W-1:0]   zsum_nxt;

  logic [a2q_pkg::TRIG_BITS-1:0] lo_a, hi_a, lo_m, hi_m, lo_p, hi_p;

  assign angle_m = angle - a2q_pkg::THIRD_TURN;
  assign angle_p = angle + a2q_pkg::THIRD_TURN;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      k_a_r  <= angle[13 -: AB];
      k_m_r  <= angle_m[13 -: AB];
      k_p_r  <= angle_p[13 -: AB];
      q1_a_r <= angle[15:14];
      q1_m_r <= angle_m[15:14];
      q1_p_r <= angle_p[15:14];
      a1_r   <= phase_a;
      b1_r   <= phase_b;
      c1_r   <= phase_c;
    end
  end

  // each angle reads T[k] and T[N-k]; sine and cosine pick between them later
  a2q_rom u_rom_a (
    .clk     (clk),
    .en      (en[1]),
    .addr_lo ({1'b0, k_a_r}),
    .addr_hi (AW'(a2q_pkg::TBL_N) - {1'b0, k_a_r}),
    .data_lo (lo_a),
    .data_hi (hi_a)
  );

  a2q_rom u_rom_m (
    .clk     (clk),
    .en      (en[1]),
    .addr_lo ({1'b0, k_m_r}),
    .addr_hi (AW'(a2q_pkg::TBL_N) - {1'b0, k_m_r}),
    .data_lo (lo_m),
    .data_hi (hi_m)
  );

  a2q_rom u_rom_p (
    .clk     (clk),
    .en      (en[1]),
    .addr_lo ({1'b0, k_p_r}),
    .addr_hi (AW'(a2q_pkg::TBL_N) - {1'b0, k_p_r}),
    .data_lo (lo_p),
    .data_hi (hi_p)
  );

  assign zsum_nxt = a2q_pkg::ZSUM_W'(a1_r) + a2q_pkg::ZSUM_W'(b1_r)
                  + a2q_pkg::ZSUM_W'(c1_r);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      q2_a_r <= q1_a_r;
      q2_m_r <= q1_m_r;
      q2_p_r <= q1_p_r;
      a2_r   <= a1_r;
      b2_r   <= b1_r;
      c2_r   <= c1_r;
      zsum_r <= zsum_nxt;
    end
  end

  always_comb begin
    lut.a      = a2_r;
    lut.b      = b2_r;
    lut.c      = c2_r;
    lut.quad_a = q2_a_r;
    lut.quad_m = q2_m_r;
    lut.quad_p = q2_p_r;
    lut.lo_a   = lo_a;
    lut.hi_a   = hi_a;
    lut.lo_m   = lo_m;
    lut.hi_m   = hi_m;
    lut.lo_p   = lo_p;
    lut.hi_p   = hi_p;
    lut.zsum   = zsum_r;
  end

endmodule

`default_nettype wire

// ----- rtl/a2q_mult.sv -----
// stages 3 and 4: signed trig values, six products, q and d sums
// also starts the divide by three of the zero-sequence sum; depends on a2q_pkg
`default_nettype none

module a2q_mult (
  input  wire logic               clk,
  input  wire logic [1:0]         en,
  input  wire a2q_pkg::lut_data_t lut,
  output a2q_pkg::mac_data_t      mac
);

  localparam int PW = a2q_pkg::PROD_W;
  localparam int SW = a2q_pkg::SUM_W;
  localparam int TW = a2q_pkg::TRIG_BITS;

  logic signed [TW:0] cos_a, sin_a, cos_m, sin_m, cos_p, sin_p;
  logic signed [PW-1:0] pc_a_r, ps_a_r, pc_m_r, ps_m_r, pc_p_r, ps_p_r;
  logic                 zneg3_r;
  logic [a2q_pkg::QUO_W-1:0] zmag3_r;
  logic signed [a2q_pkg::ZSUM_W-1:0] zabs;

  logic signed [SW-1:0] sq_r, sd_r;
  logic                 zneg4_r;
  logic [a2q_pkg::QUO_W-1:0] zmag4_r, zest_r;

  // odd quadrants swap T[k] and T[N-k]; cosine is sine one quadrant ahead
  assign sin_a = a2q_pkg::trig_val(lut.quad_a[0] ? lut.hi_a : lut.lo_a, lut.quad_a[1]);
  assign cos_a = a2q_pkg::trig_val(lut.quad_a[0] ? lut.lo_a : lut.hi_a,
                                   lut.quad_a[1] ^ lut.quad_a[0]);
  assign sin_m = a2q_pkg::trig_val(lut.quad_m[0] ? lut.hi_m : lut.lo_m, lut.quad_m[1]);
  assign cos_m = a2q_pkg::trig_val(lut.quad_m[0] ? lut.lo_m : lut.hi_m,
                                   lut.quad_m[1] ^ lut.quad_m[0]);
  assign sin_p = a2q_pkg::trig_val(lut.quad_p[0] ? lut.hi_p : lut.lo_p, lut.quad_p[1]);
  assign cos_p = a2q_pkg::trig_val(lut.quad_p[0] ? lut.lo_p : lut.hi_p,
                                   lut.quad_p[1] ^ lut.quad_p[0]);

  assign zabs = lut.zsum[a2q_pkg::ZSUM_W-1] ? -lut.zsum : lut.zsum;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pc_a_r  <= PW'(lut.a) * PW'(cos_a);
      ps_a_r  <= PW'(lut.a) * PW'(sin_a);
      pc_m_r  <= PW'(lut.b) * PW'(cos_m);
      ps_m_r  <= PW'(lut.b) * PW'(sin_m);
      pc_p_r  <= PW'(lut.c) * PW'(cos_p);
      ps_p_r  <= PW'(lut.c) * PW'(sin_p);
      zneg3_r <= lut.zsum[a2q_pkg::ZSUM_W-1];
      // rounded |sum|/3 is floor((|sum|+1)/3)
      zmag3_r <= a2q_pkg::QUO_W'(unsigned'(zabs)) + a2q_pkg::QUO_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sq_r    <= SW'(pc_a_r) + SW'(pc_m_r) + SW'(pc_p_r);
      sd_r    <= SW'(ps_a_r) + SW'(ps_m_r) + SW'(ps_p_r);
      zneg4_r <= zneg3_r;
      zmag4_r <= zmag3_r;
      zest_r  <= a2q_pkg::div3_est(zmag3_r);
    end
  end

  always_comb begin
    mac.sq     = sq_r;
    mac.sd     = sd_r;
    mac.z_neg  = zneg4_r;
    mac.z_mag1 = zmag4_r;
    mac.z_est  = zest_r;
  end

endmodule

`default_nettype wire

// ----- rtl/a2q_scale.sv -----
// stages 5 to 7: 2/3 scaling with round to nearest, saturation, output register
// divides by three as multiply then correct; depends on a2q_pkg
`default_nettype none

module a2q_scale (
  input  wire logic                         clk,
  input  wire logic [2:0]                   en,
  input  wire a2q_pkg::mac_data_t           mac,
  output logic signed [a2q_pkg::QD_W-1:0]   q_axis,
  output logic signed [a2q_pkg::QD_W-1:0]   d_axis,
  output logic signed [15:0]                zero_axis
);

  localparam int MW = a2q_pkg::MAG_W;
  localparam int UW = a2q_pkg::U_W;
  localparam int QW = a2q_pkg::QUO_W;
  localparam int TW = a2q_pkg::TRIG_BITS;

  logic [MW-1:0] mag_q, mag_d;
  logic [UW-1:0] u_q, u_d;
  logic [QW-1:0] zq;
  logic [QW-1:0] zs;

  logic [QW-1:0] vq5_r, vd5_r;
  logic          qneg5_r, dneg5_r;
  logic signed [15:0] z5_r;

  logic [QW-1:0] vq6_r, vd6_r, eq6_r, ed6_r;
  logic          qneg6_r, dneg6_r;
  logic signed [15:0] z6_r;

  logic signed [a2q_pkg::QD_W-1:0] q_axis_r, d_axis_r;
  logic signed [15:0]              zero_axis_r;

  assign mag_q = mac.sq[a2q_pkg::SUM_W-1] ? MW'(-mac.sq) : MW'(mac.sq);
  assign mag_d = mac.sd[a2q_pkg::SUM_W-1] ? MW'(-mac.sd) : MW'(mac.sd);
  // round(2S / (3*2^(TW-1))) = floor(((4|S| + 3*2^(TW-1)) >> TW) / 3)
  assign u_q = (UW'(mag_q) << 2) + a2q_pkg::RND_OFS;
  assign u_d = (UW'(mag_d) << 2) + a2q_pkg::RND_OFS;

  assign zq = a2q_pkg::div3_fix(mac.z_mag1, mac.z_est);
  assign zs = mac.z_neg ? -zq : zq;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      vq5_r   <= u_q[TW +: QW];
      vd5_r   <= u_d[TW +: QW];
      qneg5_r <= mac.sq[a2q_pkg::SUM_W-1];
      dneg5_r <= mac.sd[a2q_pkg::SUM_W-1];
      z5_r    <= signed'(zs[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      vq6_r   <= vq5_r;
      vd6_r   <= vd5_r;
      eq6_r   <= a2q_pkg::div3_est(vq5_r);
      ed6_r   <= a2q_pkg::div3_est(vd5_r);
      qneg6_r <= qneg5_r;
      dneg6_r <= dneg5_r;
      z6_r    <= z5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      q_axis_r    <= a2q_pkg::sat_qd(a2q_pkg::div3_fix(vq6_r, eq6_r), qneg6_r);
      d_axis_r    <= a2q_pkg::sat_qd(a2q_pkg::div3_fix(vd6_r, ed6_r), dneg6_r);
      zero_axis_r <= z6_r;
    end
  end

  assign q_axis    = q_axis_r;
  assign d_axis    = d_axis_r;
  assign zero_axis = zero_axis_r;

endmodule

`default_nettype wire

// ----- rtl/abc_to_qd0_frame_transform.sv -----
// abc to qd0 frame transform (park transform, krause convention)
// Input stream in_*: one request per item, in_tdata holds from bit 0 up
//   angle[15:0], phase_a[31:16], phase_b[47:32], phase_c[63:48].
// Output stream out_*: one result per request, out_tdata holds from bit 0 up
//   q_axis[16:0], d_axis[33:17], zero_axis[49:34], zeros in [55:50].
// Pipeline: out_tvalid rises once the request has passed the seven register
//   stages (angle/address, sine rom read, multiply, sum, round,
//   divide-by-three estimate, correct and saturate).
// Throughput: one item per clock while out_tready stays high.
// Stall: each stage holds while the stage after it is full and stalled; empty
//   stages keep filling, so in_tready drops only once all seven stages hold
//   an item and out_tready is low. Nothing is dropped or repeated.
// Reset: rst_n low clears all valid bits; the sine table is a constant rom,
//   so the block takes requests in the first cycle after reset.
// Angle bits below the table address are ignored (no interpolation).
`default_nettype none
`include "abc_to_qd0_frame_transform_defines.svh"

module abc_to_qd0_frame_transform (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // angle, phase_a, phase_b, phase_c
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata   // q_axis, d_axis, zero_axis, zero pad
);

  localparam int NS = a2q_pkg::NUM_STAGES;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS-1:0] en;

  a2q_pkg::lut_data_t lut;
  a2q_pkg::mac_data_t mac;

  logic signed [a2q_pkg::QD_W-1:0] q_axis;
  logic signed [a2q_pkg::QD_W-1:0] d_axis;
  logic signed [15:0]              zero_axis;

  // a stage may load when it is empty or the stage after it moves
  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (en[0]) begin
      v_nxt[0] = in_tvalid;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  a2q_lookup u_lookup (
    .clk     (clk),
    .en      (en[1:0]),
    .angle   (in_tdata[15:0]),
    .phase_a (signed'(in_tdata[31:16])),
    .phase_b (signed'(in_tdata[47:32])),
    .phase_c (signed'(in_tdata[63:48])),
    .lut     (lut)
  );

  a2q_mult u_mult (
    .clk (clk),
    .en  (en[3:2]),
    .lut (lut),
    .mac (mac)
  );

  a2q_scale u_scale (
    .clk       (clk),
    .en        (en[6:4]),
    .mac       (mac),
    .q_axis    (q_axis),
    .d_axis    (d_axis),
    .zero_axis (zero_axis)
  );

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NS-1];
  assign out_tdata  = {6'b0, zero_axis, d_axis, q_axis};

  `A2Q_ASSERT_NEXT(a_accept_fills, in_tvalid && in_tready, v_r[0], "accepted request lost at stage one")
  `A2Q_ASSERT_SAME(a_ready_full, !in_tready, (&v_r) && !out_tready, "input stalled with a free stage")
  `A2Q_ASSERT_NEXT(a_stage_moves, en[1] && v_r[0], v_r[1], "request dropped between stages")

endmodule

`default_nettype wire
